[hw/rtl/gss_pkg.sv]
`timescale 1ns / 1ps
// Package for the gear shift request sequencer: widths, register indexes,
// phase and direction codes. No dependencies.
package gss_pkg;

  localparam int TIME_BITS          = 32;
  localparam int FREQ_FRACTION_BITS = 4;

  localparam int ENG_W   = 20;
  localparam int WHEEL_W = 16;
  localparam int RPM_W   = 15;
  localparam int TEETH_W = 8;
  localparam int THR_W   = 7;
  localparam int WIDTH_W = 16;
  localparam int CFG_W   = 48;
  localparam int IDX_W   = 3;

  // engine_hz * 60 against rpm * teeth * 2^FREQ_FRACTION_BITS
  localparam int LHS_W = ENG_W + 6;
  localparam int RHS_W = RPM_W + TEETH_W + FREQ_FRACTION_BITS;
  localparam int CMP_W = (LHS_W > RHS_W) ? LHS_W : RHS_W;

  localparam logic [IDX_W-1:0] REG_UPSHIFT_RPM      = 3'd0;
  localparam logic [IDX_W-1:0] REG_DOWNSHIFT_RPM    = 3'd1;
  localparam logic [IDX_W-1:0] REG_MIN_WHEEL_HZ     = 3'd2;
  localparam logic [IDX_W-1:0] REG_COOLDOWN_MS      = 3'd3;
  localparam logic [IDX_W-1:0] REG_THROTTLE_ON_PCT  = 3'd4;
  localparam logic [IDX_W-1:0] REG_TRANSMISSION_IST = 3'd5;
  localparam logic [IDX_W-1:0] REG_ENGINE_TEETH     = 3'd6;
  localparam logic [IDX_W-1:0] REG_PULSE_WIDTHS_MS  = 3'd7;

  localparam logic signed [3:0] GEAR_NEUTRAL   = 4'sd0;
  localparam logic signed [3:0] GEAR_FIRST     = 4'sd1;
  localparam logic signed [3:0] GEAR_SECOND    = 4'sd2;
  localparam logic signed [3:0] GEAR_TOP_IST   = 4'sd4;
  localparam logic signed [3:0] GEAR_TOP_NORM  = 4'sd6;

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_PULSE = 2'd1,
    PH_COOL  = 2'd2
  } phase_t;

  typedef enum logic [1:0] {
    DIR_NONE = 2'd0,
    DIR_UP   = 2'd1,
    DIR_DOWN = 2'd2
  } dir_t;

endpackage

[hw/rtl/gear_shift_request_sequencer.sv]
`timescale 1ns / 1ps
// Gear shift request sequencer: phase machine, button and mode history,
// manual override and automatic shift rules. Depends on gss_pkg.
// Input beat to result beat: input register, then result register.
// Throughput: one beat per cycle unless stalled; phase and history update per beat.
// Reset (rst, synchronous): idle, no direction, buttons taken as pressed,
// override clear, registers at their default values.
module gear_shift_request_sequencer
  import gss_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_write_en,
  input  logic [IDX_W-1:0]         cfg_index,
  input  logic [CFG_W-1:0]         cfg_data,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [TIME_BITS-1:0]     now_ms,
  input  logic [ENG_W-1:0]         engine_hz,
  input  logic [WHEEL_W-1:0]       wheel_left_hz,
  input  logic [WHEEL_W-1:0]       wheel_right_hz,
  input  logic signed [3:0]        gear,
  input  logic [THR_W-1:0]         throttle_pct,
  input  logic                     up_button,
  input  logic                     down_button,
  input  logic                     auto_on,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic                     up_drive,
  output logic                     down_drive,
  output logic [1:0]               phase_now,
  output logic                     override_latched,
  output logic                     shift_started
);

  logic [RPM_W-1:0]   up_rpm_limit;
  logic [RPM_W-1:0]   down_rpm_limit;
  logic [WHEEL_W-1:0] wheel_floor_hz;
  logic [WIDTH_W-1:0] cool_period_ms;
  logic [THR_W-1:0]   throttle_floor;
  logic               transmission_ist;
  logic [TEETH_W-1:0] engine_teeth;
  logic [CFG_W-1:0]   pulse_widths_ms;

  logic                 s_valid;
  logic [TIME_BITS-1:0] s_now;
  logic [ENG_W-1:0]     s_eng;
  logic [WHEEL_W-1:0]   s_wl;
  logic [WHEEL_W-1:0]   s_wr;
  logic signed [3:0]    s_gear;
  logic [THR_W-1:0]     s_thr;
  logic                 s_up;
  logic                 s_down;
  logic                 s_auto;

  phase_t               phase, phase_next;
  logic [TIME_BITS-1:0] phase_start_ms, phase_start_ms_next;
  logic [WIDTH_W-1:0]   active_width_ms, active_width_ms_next;
  dir_t                 shift_direction, shift_direction_next;
  logic                 last_up_button, last_down_button, last_auto_on;
  logic                 override_flag, override_flag_next;
  logic                 started;

  logic advance;
  logic take;

  assign advance  = s_valid && (!out_valid || !out_stall);
  assign take     = in_valid && !in_stall;
  assign in_stall = s_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      up_rpm_limit     <= RPM_W'(11000);
      down_rpm_limit   <= RPM_W'(5000);
      wheel_floor_hz   <= WHEEL_W'(16);
      cool_period_ms   <= WIDTH_W'(300);
      throttle_floor   <= THR_W'(20);
      transmission_ist <= 1'b0;
      engine_teeth     <= TEETH_W'(1);
      pulse_widths_ms  <= '0;
    end else if (cfg_write_en) begin
      unique case (cfg_index)
        REG_UPSHIFT_RPM:      up_rpm_limit     <= cfg_data[RPM_W-1:0];
        REG_DOWNSHIFT_RPM:    down_rpm_limit   <= cfg_data[RPM_W-1:0];
        REG_MIN_WHEEL_HZ:     wheel_floor_hz   <= cfg_data[WHEEL_W-1:0];
        REG_COOLDOWN_MS:      cool_period_ms   <= cfg_data[WIDTH_W-1:0];
        REG_THROTTLE_ON_PCT:  throttle_floor   <= cfg_data[THR_W-1:0];
        REG_TRANSMISSION_IST: transmission_ist <= cfg_data[0];
        REG_ENGINE_TEETH:     engine_teeth     <= cfg_data[TEETH_W-1:0];
        REG_PULSE_WIDTHS_MS:  pulse_widths_ms  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid <= 1'b0;
    end else if (take) begin
      s_valid <= 1'b1;
    end else if (advance) begin
      s_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      s_now  <= now_ms;
      s_eng  <= engine_hz;
      s_wl   <= wheel_left_hz;
      s_wr   <= wheel_right_hz;
      s_gear <= gear;
      s_thr  <= throttle_pct;
      s_up   <= up_button;
      s_down <= down_button;
      s_auto <= auto_on;
    end
  end

  // Rule terms
  logic [TEETH_W-1:0]         teeth_eff;
  logic [RPM_W+TEETH_W-1:0]   up_prod, down_prod;
  logic [CMP_W-1:0]           lhs, up_rhs, down_rhs;
  logic [LHS_W-1:0]           eng_ext;
  logic [WHEEL_W:0]           wheel_sum, wheel_min2;
  logic                       moving, on_thr;
  logic signed [3:0]          top_gear;
  logic [TIME_BITS-1:0]       elapsed;
  logic                       up_edge, down_edge, mode_change;
  logic                       manual, to_neutral;
  dir_t                       auto_req, req;

  always_comb begin
    teeth_eff  = (engine_teeth == '0) ? TEETH_W'(1) : engine_teeth;
    up_prod    = (RPM_W+TEETH_W)'(up_rpm_limit) * (RPM_W+TEETH_W)'(teeth_eff);
    down_prod  = (RPM_W+TEETH_W)'(down_rpm_limit) * (RPM_W+TEETH_W)'(teeth_eff);
    up_rhs     = CMP_W'(up_prod) << FREQ_FRACTION_BITS;
    down_rhs   = CMP_W'(down_prod) << FREQ_FRACTION_BITS;
    eng_ext    = LHS_W'(s_eng);
    lhs        = CMP_W'((eng_ext << 6) - (eng_ext << 2));
    wheel_sum  = (WHEEL_W+1)'(s_wl) + (WHEEL_W+1)'(s_wr);
    wheel_min2 = {wheel_floor_hz, 1'b0};
    moving     = wheel_sum >= wheel_min2;
    on_thr     = s_thr >= throttle_floor;
    top_gear   = transmission_ist ? GEAR_TOP_IST : GEAR_TOP_NORM;
    auto_req   = DIR_NONE;
    if (s_gear >= GEAR_NEUTRAL) begin
      if (on_thr && lhs >= up_rhs && s_gear >= GEAR_FIRST && s_gear < top_gear && moving) begin
        auto_req = DIR_UP;
      end else if (!on_thr && lhs <= down_rhs && s_gear >= GEAR_SECOND) begin
        auto_req = DIR_DOWN;
      end
    end
  end

  // Next state
  always_comb begin
    phase_next           = phase;
    phase_start_ms_next  = phase_start_ms;
    active_width_ms_next = active_width_ms;
    shift_direction_next = shift_direction;
    override_flag_next   = override_flag;
    started              = 1'b0;
    req                  = DIR_NONE;
    manual               = 1'b0;
    to_neutral           = 1'b0;
    elapsed              = s_now - phase_start_ms;

    unique case (phase)
      PH_PULSE: begin
        if (elapsed >= TIME_BITS'(active_width_ms)) begin
          shift_direction_next = DIR_NONE;
          phase_next           = PH_COOL;
          phase_start_ms_next  = s_now;
        end
      end
      PH_COOL: begin
        if (elapsed >= TIME_BITS'(cool_period_ms)) begin
          phase_next = PH_IDLE;
        end
      end
      default: ;
    endcase

    mode_change = s_auto != last_auto_on;
    up_edge     = s_up && !last_up_button && !mode_change;
    down_edge   = s_down && !last_down_button && !mode_change;
    if (s_auto && !last_auto_on) begin
      override_flag_next = 1'b0;
    end

    if (phase_next == PH_IDLE) begin
      manual = !s_auto || override_flag_next || (!moving && s_gear <= GEAR_SECOND);
      priority if (manual) begin
        if (up_edge) begin
          req = DIR_UP;
        end else if (down_edge) begin
          req = DIR_DOWN;
        end
      end else if (up_edge || down_edge) begin
        override_flag_next = 1'b1;
        req = up_edge ? DIR_UP : DIR_DOWN;
      end else begin
        req = auto_req;
      end
      if (req != DIR_NONE) begin
        to_neutral = !moving && ((s_gear == GEAR_FIRST && req == DIR_UP) ||
                                 (s_gear == GEAR_SECOND && req == DIR_DOWN));
        if (transmission_ist) begin
          active_width_ms_next = pulse_widths_ms[15:0];
        end else if (to_neutral) begin
          active_width_ms_next = pulse_widths_ms[47:32];
        end else begin
          active_width_ms_next = pulse_widths_ms[31:16];
        end
        shift_direction_next = req;
        phase_next           = PH_PULSE;
        phase_start_ms_next  = s_now;
        started              = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= PH_IDLE;
      phase_start_ms   <= '0;
      active_width_ms  <= '0;
      shift_direction  <= DIR_NONE;
      last_up_button   <= 1'b1;
      last_down_button <= 1'b1;
      last_auto_on     <= 1'b0;
      override_flag    <= 1'b0;
    end else if (advance) begin
      phase            <= phase_next;
      phase_start_ms   <= phase_start_ms_next;
      active_width_ms  <= active_width_ms_next;
      shift_direction  <= shift_direction_next;
      last_up_button   <= s_up;
      last_down_button <= s_down;
      last_auto_on     <= s_auto;
      override_flag    <= override_flag_next;
    end
  end

  // Result beat
  logic       up_drive_next, down_drive_next;
  logic [1:0] phase_now_next;

  always_comb begin
    up_drive_next   = shift_direction_next == DIR_UP;
    down_drive_next = shift_direction_next == DIR_DOWN;
    phase_now_next  = phase_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      up_drive         <= up_drive_next;
      down_drive       <= down_drive_next;
      phase_now        <= phase_now_next;
      override_latched <= override_flag_next;
      shift_started    <= started;
    end
  end

endmodule
